// File: sv/silu_pkg.sv
package silu_pkg;

  localparam int XW = 16;
  localparam int MagW = XW + 1;
  localparam int FracBits = 11;
  localparam int SigW = 16;
  localparam int DiffW = 13;
  localparam int ProdW = DiffW + FracBits;
  localparam logic [SigW-1:0] SigOne = 16'd32768;
  localparam logic [FracBits:0] RoundHalf = 12'd1024;

  typedef struct packed {
    logic ld_seg;
    logic ld_sig;
  } sig_ctl_t;

  // Sigmoid at the integer knots 0..8, unsigned Q1.15.
  function automatic logic [SigW-1:0] sig_knot(input logic [3:0] idx);
    logic [SigW-1:0] k;
    case (idx)
      4'd0: k = 16'd16384;
      4'd1: k = 16'd23955;
      4'd2: k = 16'd28862;
      4'd3: k = 16'd31214;
      4'd4: k = 16'd32179;
      4'd5: k = 16'd32549;
      4'd6: k = 16'd32687;
      4'd7: k = 16'd32738;
      4'd8: k = 16'd32757;
      default: k = SigOne;
    endcase
    return k;
  endfunction

endpackage

// File: sv/silu_sig.sv
module silu_sig (
  input  logic                          clk,
  input  silu_pkg::sig_ctl_t            ctl,
  input  logic [silu_pkg::MagW-1:0]     mag,
  input  logic                          neg,
  output logic [silu_pkg::SigW-1:0]     sig
);

  logic [2:0]                       seg_idx;
  logic [silu_pkg::FracBits-1:0]    frac;
  logic [silu_pkg::SigW-1:0]        knot_lo;
  logic [silu_pkg::SigW-1:0]        knot_hi;
  logic [silu_pkg::DiffW-1:0]       diff;
  logic [silu_pkg::SigW-1:0]        lo;
  logic [silu_pkg::ProdW-1:0]       prod;
  logic                             big;
  logic                             neg_seg;
  logic [silu_pkg::ProdW:0]         rnd_sum;
  logic [silu_pkg::SigW-1:0]        sig_mag;
  logic [silu_pkg::SigW-1:0]        sig_pos;

  assign seg_idx = mag[silu_pkg::FracBits +: 3];
  assign frac    = mag[silu_pkg::FracBits-1:0];
  assign knot_lo = silu_pkg::sig_knot({1'b0, seg_idx});
  assign knot_hi = silu_pkg::sig_knot({1'b0, seg_idx} + 4'd1);
  assign diff    = silu_pkg::DiffW'(knot_hi - knot_lo);

  always_ff @(posedge clk) begin
    if (ctl.ld_seg) begin
      lo      <= knot_lo;
      prod    <= diff * frac;
      big     <= |mag[silu_pkg::MagW-1:silu_pkg::FracBits+3];
      neg_seg <= neg;
    end
  end

  assign rnd_sum = {1'b0, prod} + (silu_pkg::ProdW+1)'(silu_pkg::RoundHalf);
  assign sig_mag = lo + silu_pkg::SigW'(rnd_sum[silu_pkg::ProdW:silu_pkg::FracBits]);
  assign sig_pos = big ? silu_pkg::SigOne : sig_mag;

  always_ff @(posedge clk) begin
    if (ctl.ld_sig) begin
      sig <= neg_seg ? (silu_pkg::SigOne - sig_pos) : sig_pos;
    end
  end

endmodule

// File: sv/silu_activation.sv
// SiLU activation, y = x * sigmoid(x), on signed Q4.11 samples.
// Input channel: in_valid / in_ready carry x_sample and in_last.
// Output channel: out_valid / out_ready carry y_sample and out_last, where
// out_last is the in_last of the same item and results leave in input order.
// Sigmoid is a piecewise-linear curve over integer knots, mirrored for
// negative inputs; the product is rounded half up and saturated to 16 bits.
// The datapath is a five-stage pipeline: magnitude, knot lookup and slope
// multiply, interpolation, x times sigmoid, round and saturate. Items pass
// through these stages in that order, and one item can enter in every
// cycle unless every stage holds an item and the receiver stalls.
// Each stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up while the receiver stalls and
// in_ready only drops once every stage holds an item.
// Reset clears all valid bits; the pipeline is empty and in_ready is high.
module silu_activation (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [silu_pkg::XW-1:0] x_sample,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [silu_pkg::XW-1:0] y_sample,
  output logic                         out_last
);

  localparam int PW = silu_pkg::XW + silu_pkg::SigW + 1;

  logic v_a, v_b, v_c, v_d;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;
  logic signed [silu_pkg::XW-1:0] x_a, x_b, x_c;
  logic last_a, last_b, last_c, last_d;
  logic neg_a;
  logic [silu_pkg::MagW-1:0] mag_a;
  logic [silu_pkg::MagW-1:0] x_ext;
  logic [silu_pkg::SigW-1:0] sig_c;
  logic signed [PW-1:0] p_d;
  logic signed [PW:0] p_rnd;
  logic signed [PW:0] y_full;
  silu_pkg::sig_ctl_t sig_ctl;

  assign rdy_e    = !out_valid || out_ready;
  assign rdy_d    = !v_d || rdy_e;
  assign rdy_c    = !v_c || rdy_d;
  assign rdy_b    = !v_b || rdy_c;
  assign rdy_a    = !v_a || rdy_b;
  assign in_ready = rdy_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a       <= 1'b0;
      v_b       <= 1'b0;
      v_c       <= 1'b0;
      v_d       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy_a) v_a <= in_valid;
      if (rdy_b) v_b <= v_a;
      if (rdy_c) v_c <= v_b;
      if (rdy_d) v_d <= v_c;
      if (rdy_e) out_valid <= v_d;
    end
  end

  assign x_ext = {x_sample[silu_pkg::XW-1], x_sample};

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      x_a    <= x_sample;
      last_a <= in_last;
      neg_a  <= x_sample[silu_pkg::XW-1];
      mag_a  <= x_sample[silu_pkg::XW-1] ? (~x_ext + 1'b1) : x_ext;
    end
  end

  assign sig_ctl.ld_seg = rdy_b;
  assign sig_ctl.ld_sig = rdy_c;

  silu_sig u_sig (
    .clk (clk),
    .ctl (sig_ctl),
    .mag (mag_a),
    .neg (neg_a),
    .sig (sig_c)
  );

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      x_b    <= x_a;
      last_b <= last_a;
    end
    if (rdy_c) begin
      x_c    <= x_b;
      last_c <= last_b;
    end
    if (rdy_d) begin
      p_d    <= x_c * $signed({1'b0, sig_c});
      last_d <= last_c;
    end
  end

  assign p_rnd  = {p_d[PW-1], p_d} + (PW+1)'(16384);
  assign y_full = p_rnd >>> 15;

  always_ff @(posedge clk) begin
    if (rdy_e) begin
      out_last <= last_d;
      if (y_full > (PW+1)'(32767)) begin
        y_sample <= 16'sh7FFF;
      end else if (y_full < -(PW+1)'(32768)) begin
        y_sample <= 16'sh8000;
      end else begin
        y_sample <= y_full[silu_pkg::XW-1:0];
      end
    end
  end

endmodule

// File: sv/silu_checker.sv
module silu_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [silu_pkg::XW-1:0]      x_sample,
  input logic                         in_last,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [silu_pkg::XW-1:0]      y_sample,
  input logic                         out_last
);

  // An item accepted at the input, with the receiver ready and no reset since.
  sequence flow5;
    $past(in_valid && in_ready, 5) && $past(out_ready, 1) &&
    $past(out_ready, 2) && $past(out_ready, 3) && $past(out_ready, 4) &&
    !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3) && !$past(rst, 4) &&
    !$past(rst, 5);
  endsequence

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("in_ready low while the output stage is empty");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid)
    else $error("out_valid high right after reset");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    flow5 |-> out_valid && out_last == $past(in_last, 5))
    else $error("item did not arrive after four cycles of free flow");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    flow5 ##0 ($past(x_sample, 5) == '0) |-> y_sample == '0)
    else $error("zero input gave a nonzero result");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(y_sample) && $stable(out_last))
    else $error("stalled output item changed");

endmodule

bind silu_activation silu_checker u_silu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .x_sample  (x_sample),
  .in_last   (in_last),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .y_sample  (y_sample),
  .out_last  (out_last)
);

// File: bench/silu_activation_tb.sv
`timescale 1ns / 1ps

typedef struct {
  logic signed [silu_pkg::XW-1:0] y;
  logic                           last;
} silu_result_t;

typedef enum int {
  RX_OPEN,
  RX_COIN,
  RX_SPARSE,
  RX_PERIODIC
} rx_mode_t;

class silu_scoreboard;
  silu_result_t expected_q[$];
  int           knot_tab[9];
  int           errors;
  int           n_in;
  int           n_out;
  int           n_neg;
  int           n_flat;
  int           n_last;

  function new();
    knot_tab = '{16384, 23955, 28862, 31214, 32179, 32549, 32687, 32738, 32757};
    errors = 0;
    n_in = 0;
    n_out = 0;
    n_neg = 0;
    n_flat = 0;
    n_last = 0;
  endfunction

  function logic signed [silu_pkg::XW-1:0] silu_of(logic signed [silu_pkg::XW-1:0] x);
    int     xi;
    int     mag;
    int     seg;
    int     frac;
    int     sig;
    longint prod;
    longint y;
    xi = x;
    mag = (xi < 0) ? -xi : xi;
    seg = mag >> 11;
    frac = mag & 2047;
    if (seg >= 8) begin
      sig = 32768;
    end else begin
      sig = knot_tab[seg] + (((knot_tab[seg+1] - knot_tab[seg]) * frac + 1024) >> 11);
    end
    if (xi < 0) begin
      sig = 32768 - sig;
    end
    prod = longint'(xi) * longint'(sig) + 64'sd16384;
    y = prod >>> 15;
    if (y > 32767) begin
      y = 32767;
    end
    if (y < -32768) begin
      y = -32768;
    end
    return y[silu_pkg::XW-1:0];
  endfunction

  function void note_sample(logic signed [silu_pkg::XW-1:0] x, logic last);
    silu_result_t e;
    e.y = silu_of(x);
    e.last = last;
    expected_q.push_back(e);
    n_in++;
    if (x < 0) begin
      n_neg++;
    end
    if (x >= 16384 || x <= -16384) begin
      n_flat++;
    end
    if (last) begin
      n_last++;
    end
  endfunction

  function void check_result(logic signed [silu_pkg::XW-1:0] y, logic last);
    silu_result_t e;
    if (expected_q.size() == 0) begin
      $error("unexpected result: y_sample %0d out_last %0d", y, last);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    n_out++;
    if (y !== e.y) begin
      $error("y_sample: expected %0d, actual %0d", e.y, y);
      errors++;
    end
    if (last !== e.last) begin
      $error("out_last: expected %0d, actual %0d", e.last, last);
      errors++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module silu_activation_tb;

  localparam int RandomItems = 950;
  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 90;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic signed [silu_pkg::XW-1:0] x_sample = '0;
  logic                           in_last = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic signed [silu_pkg::XW-1:0] y_sample;
  logic                           out_last;

  silu_scoreboard sb = new();
  int             cycles = 0;
  int             held_for = 0;

  silu_activation dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .x_sample  (x_sample),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .y_sample  (y_sample),
    .out_last  (out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("silu_activation regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        sb.note_sample(x_sample, in_last);
      end
      if (out_valid && out_ready) begin
        sb.check_result(y_sample, out_last);
      end
    end
  end

  initial begin
    rx_mode_t mode;
    int       left;
    int       hold;
    bit       hold_done;
    left = 0;
    hold = 0;
    hold_done = 1'b0;
    mode = RX_OPEN;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        left = $urandom_range(20, 120);
      end
      left--;
      if (!hold_done && sb.n_in >= 400) begin
        hold = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold > 0) begin
        hold--;
        held_for++;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          RX_OPEN:     out_ready <= 1'b1;
          RX_COIN:     out_ready <= ($urandom_range(0, 1) == 1);
          RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
          RX_PERIODIC: out_ready <= (cycles % 3 != 0);
          default:     out_ready <= 1'b1;
        endcase
      end
      @(posedge clk);
    end
  end

  task automatic send_item(logic signed [silu_pkg::XW-1:0] x, logic last);
    in_valid <= 1'b1;
    x_sample <= x;
    in_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic pause_sender(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic signed [silu_pkg::XW-1:0] pick_sample();
    int r;
    int k;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      return silu_pkg::XW'($urandom);
    end else if (r < 8) begin
      return silu_pkg::XW'($urandom_range(0, 32767) - 16384);
    end else begin
      k = int'($urandom_range(0, 16)) - 8;
      return silu_pkg::XW'(k * 2048 + int'($urandom_range(0, 4)) - 2);
    end
  endfunction

  initial begin
    logic signed [silu_pkg::XW-1:0] directed[$];
    int                             sent;
    int                             burst;
    bit                             ok;
    directed = '{16'sd0, 16'sd1, -16'sd1, 16'sd1024, -16'sd1024, 16'sd2047, 16'sd2048,
                 -16'sd2048, 16'sd6144, -16'sd10240, 16'sd14335, 16'sd14336,
                 16'sd16383, 16'sd16384, -16'sd16383, -16'sd16384, -16'sd16385,
                 16'sd32767, -16'sd32767, -16'sd32768, 16'sh5555, 16'shAAAA};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      send_item(directed[i], i[0]);
    end
    pause_sender(3);

    sent = 0;
    while (sent < RandomItems) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst; i++) begin
        send_item(pick_sample(), $urandom_range(0, 7) == 0);
        sent++;
      end
      if ($urandom_range(0, 2) != 0) begin
        pause_sender($urandom_range(1, 6));
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    ok = (sb.errors == 0) && (sb.pending() == 0);
    $display("Checked %0d results for %0d samples: %0d negative, %0d beyond the sigmoid knots,",
             sb.n_out, sb.n_in, sb.n_neg, sb.n_flat);
    $display("%0d buffer ends marked; output held off for %0d cycles in one stretch.",
             sb.n_last, held_for);
    if (ok) begin
      $display("silu_activation regression: pass");
    end else begin
      $display("silu_activation regression: fail");
    end
    $finish;
  end

endmodule
